@@ design/thumbnail_nibble_deinterleave_assert.svh @@
// ---------------------------------------------------------------------------
// Thumbnail nibble deinterleaver assertion macros
// Concurrent assertion wrappers clocked on clk_i and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef THUMBNAIL_NIBBLE_DEINTERLEAVE_ASSERT_SVH
`define THUMBNAIL_NIBBLE_DEINTERLEAVE_ASSERT_SVH

`ifndef SYNTH
// Implication or plain property checked at every edge outside reset.
`define TND_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Condition that must never be true outside reset.
`define TND_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define TND_ASSERT(lbl, prop)
`define TND_ASSERT_NEVER(lbl, cond)
`endif

`endif

@@ design/tnd_pkg.sv @@
// ---------------------------------------------------------------------------
// Thumbnail nibble deinterleaver package
// Frame geometry, counter widths and the types shared by the modules.
// ---------------------------------------------------------------------------
`default_nettype none

package tnd_pkg;

  // Frame geometry in pixels.
  localparam int unsigned ThumbWidth     = 80;
  localparam int unsigned ThumbHeight    = 60;
  localparam int unsigned GroupNibbles   = 2 * ThumbWidth;
  localparam int unsigned TripletNibbles = 3 * (ThumbWidth / 2);
  localparam int unsigned RowPairs       = ThumbHeight / 2;

  // Counter and field widths.
  localparam int unsigned PosW  = $clog2(GroupNibbles);
  localparam int unsigned QuotW = $clog2(GroupNibbles / 3 + 1);
  localparam int unsigned RowW  = (RowPairs > 1) ? $clog2(RowPairs) : 1;
  localparam int unsigned XW    = 7;
  localparam int unsigned YW    = 6;
  localparam int unsigned GrayW = 8;
  localparam int unsigned NibW  = 4;

  // Phase inside a triplet.
  localparam logic [1:0] Ph0 = 2'd0;
  localparam logic [1:0] Ph1 = 2'd1;
  localparam logic [1:0] Ph2 = 2'd2;

  // Configuration register indexes.
  localparam logic RegInterleaveMode = 1'b0;

  // Scan mode values.
  localparam logic ModeSequential  = 1'b0;
  localparam logic ModeInterleaved = 1'b1;

  // Place of one nibble inside its two-line group.
  typedef struct packed {
    logic [PosW-1:0]  pos;
    logic [1:0]       phase;
    logic [QuotW-1:0] quot;
  } nib_t;

  // Counter state handed to the lanes.
  typedef struct packed {
    nib_t            even_nib;
    nib_t            odd_nib;
    logic [RowW-1:0] row_pair;
    logic            last;
  } pos_t;

  // Result of one lane.
  typedef struct packed {
    logic [XW-1:0]    x;
    logic [YW-1:0]    y;
    logic [GrayW-1:0] gray;
  } pix_t;

endpackage

`default_nettype wire

@@ design/tnd_pos_cnt.sv @@
// ---------------------------------------------------------------------------
// Thumbnail position counter
// Tracks the nibble index, triplet phase and quotient, and the line pair.
// ---------------------------------------------------------------------------
`default_nettype none

`include "thumbnail_nibble_deinterleave_assert.svh"

module tnd_pos_cnt (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             step_i,
  output tnd_pkg::pos_t   pos_o
);
  import tnd_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [1:0]       phase_q, phase_d;
  logic [QuotW-1:0] quot_q, quot_d;
  logic [RowW-1:0]  row_q, row_d;
  logic             wrap;
  logic             last;

  // End of a group and end of the frame.
  assign wrap = (pos_q >= PosW'(GroupNibbles - 2));
  assign last = wrap && (row_q >= RowW'(RowPairs - 1));

  // Next counter values after one byte (two nibbles).
  always_comb begin
    pos_d   = pos_q;
    phase_d = phase_q;
    quot_d  = quot_q;
    row_d   = row_q;
    if (step_i) begin
      if (wrap) begin
        pos_d   = '0;
        phase_d = Ph0;
        quot_d  = '0;
        row_d   = last ? '0 : row_q + RowW'(1);
      end else begin
        pos_d = pos_q + PosW'(2);
        case (phase_q)
          Ph0: begin
            phase_d = Ph2;
          end
          Ph1: begin
            phase_d = Ph0;
            quot_d  = quot_q + QuotW'(1);
          end
          default: begin
            phase_d = Ph1;
            quot_d  = quot_q + QuotW'(1);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= Ph0;
      quot_q  <= '0;
      row_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      quot_q  <= quot_d;
      row_q   <= row_d;
    end
  end

  // The even lane takes the counter itself; the odd lane is one nibble on.
  always_comb begin
    pos_o.even_nib.pos   = pos_q;
    pos_o.even_nib.phase = phase_q;
    pos_o.even_nib.quot  = quot_q;
    pos_o.odd_nib.pos    = pos_q + PosW'(1);
    pos_o.odd_nib.phase  = (phase_q == Ph2) ? Ph0 : phase_q + 2'd1;
    pos_o.odd_nib.quot   = (phase_q == Ph2) ? quot_q + QuotW'(1) : quot_q;
    pos_o.row_pair       = row_q;
    pos_o.last           = last;
  end

  // The nibble index stays even and inside the group.
  `TND_ASSERT(pos_in_group, (pos_q[0] == 1'b0) && (pos_q < PosW'(GroupNibbles)))
  // The line pair never passes the frame.
  `TND_ASSERT(row_in_frame, row_q < RowW'(RowPairs))
  // The last byte of a frame brings all counters back to the start.
  `TND_ASSERT(frame_restart,
    (step_i && last) |=> (pos_q == '0 && row_q == '0 && phase_q == Ph0))

endmodule

`default_nettype wire

@@ design/tnd_lane.sv @@
// ---------------------------------------------------------------------------
// Thumbnail nibble lane
// Places one nibble in the frame and turns it into a gray level.
// ---------------------------------------------------------------------------
`default_nettype none

module tnd_lane (
  input  tnd_pkg::nib_t                   nib_i,
  input  wire [tnd_pkg::RowW-1:0]         row_pair_i,
  input  wire                             mode_i,
  input  wire [tnd_pkg::NibW-1:0]         nibble_i,
  output tnd_pkg::pix_t                   pix_o
);
  import tnd_pkg::*;

  logic [PosW-1:0] seq_off;
  logic [PosW-1:0] tail_off;
  logic [XW-1:0]   x;
  logic            y_low;

  assign seq_off  = nib_i.pos - PosW'(ThumbWidth);
  assign tail_off = nib_i.pos - PosW'(TripletNibbles);

  // Column and lower-line flag for the active scan order.
  always_comb begin
    if (mode_i == ModeSequential) begin
      if (nib_i.pos < PosW'(ThumbWidth)) begin
        x     = XW'(nib_i.pos);
        y_low = 1'b0;
      end else begin
        x     = XW'(seq_off);
        y_low = 1'b1;
      end
    end else if (nib_i.pos < PosW'(TripletNibbles)) begin
      // Triplet: left upper, right upper, left lower.
      x     = XW'({nib_i.quot, (nib_i.phase == Ph1)});
      y_low = (nib_i.phase == Ph2);
    end else begin
      // Tail: odd columns of the lower line.
      x     = XW'({tail_off, 1'b1});
      y_low = 1'b1;
    end
  end

  assign pix_o.x    = x;
  assign pix_o.y    = YW'({row_pair_i, y_low});
  assign pix_o.gray = {nibble_i, {(GrayW - NibW){1'b0}}};

endmodule

`default_nettype wire

@@ design/thumbnail_nibble_deinterleave.sv @@
// ---------------------------------------------------------------------------
// Thumbnail nibble deinterleaver
// Turns raw 4-bit thumbnail bytes into two placed gray pixels per byte.
// ---------------------------------------------------------------------------
// Usage:
// Raw bytes enter on the s_axis channel (tdata = data_byte). Each accepted
// byte yields one transfer on the m_axis channel carrying both pixels: the
// high nibble as the first pixel, the low nibble as the second, each with
// its column, row and gray level. tlast marks the last byte of a frame,
// after which the position counters start over.
// A byte accepted at one edge is offered on m_axis from the next.
// Throughput is one byte per cycle while the receiver does not stall, set by
// the single output register; both nibbles are placed by two lanes in the same cycle.
// When the receiver stalls, the output register holds its transfer and the
// input accepts a new byte only in the cycle the held one leaves.
// Reset clears the counters and the output valid and selects interleaved
// mode. The APB register at byte address 0 holds interleave_mode (bit 0);
// the user must write it only while the stream is idle; the block does not enforce this.
// ---------------------------------------------------------------------------
`default_nettype none

`include "thumbnail_nibble_deinterleave_assert.svh"

module thumbnail_nibble_deinterleave (
  input  wire         clk_i,
  input  wire         rst_ni,
  // APB configuration port.
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Byte input stream.
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
  // Pixel pair output stream.
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // first_x, first_y, first_gray, second_x,
                                      // second_y, second_gray, zero fill
  output logic        m_axis_tlast    // frame_end
);
  import tnd_pkg::*;

  localparam int unsigned PixW = XW + YW + GrayW;

  logic  mode_q;
  logic  cfg_wr;
  logic  in_xfer;
  pos_t  pos;
  pix_t  first_pix, second_pix;
  logic  out_valid_q;
  logic  out_last_q;
  logic [2*PixW-1:0] out_data_q;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegInterleaveMode);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeInterleaved;
    end else if (cfg_wr) begin
      mode_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == RegInterleaveMode) ? {31'd0, mode_q} : 32'd0;

  // Input handshake: take a byte whenever the output register can move.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  tnd_pos_cnt u_pos_cnt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_xfer),
    .pos_o  (pos)
  );

  // Two lanes: high nibble and low nibble.
  tnd_lane u_lane_hi (
    .nib_i      (pos.even_nib),
    .row_pair_i (pos.row_pair),
    .mode_i     (mode_q),
    .nibble_i   (s_axis_tdata[7:4]),
    .pix_o      (first_pix)
  );

  tnd_lane u_lane_lo (
    .nib_i      (pos.odd_nib),
    .row_pair_i (pos.row_pair),
    .mode_i     (mode_q),
    .nibble_i   (s_axis_tdata[3:0]),
    .pix_o      (second_pix)
  );

  // Merge stage: both lane results packed into the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= {second_pix.gray, second_pix.y, second_pix.x,
                     first_pix.gray, first_pix.y, first_pix.x};
      out_last_q <= pos.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(48 - 2 * PixW){1'b0}}, out_data_q};
  assign m_axis_tlast  = out_last_q;

  // An accepted byte is offered on the output at the next edge.
  `TND_ASSERT(accept_to_valid, in_xfer |=> m_axis_tvalid)
  // A held transfer is never overwritten by a new byte.
  `TND_ASSERT_NEVER(no_overrun, in_xfer && out_valid_q && !m_axis_tready)
  // The frame's last byte ends on the bottom-right pixel.
  `TND_ASSERT(last_at_corner,
    (m_axis_tvalid && m_axis_tlast) |->
      (out_data_q[PixW +: XW] == XW'(ThumbWidth - 1) &&
       out_data_q[PixW + XW +: YW] == YW'(2 * RowPairs - 1)))

endmodule

`default_nettype wire

@@ sim/tb_thumbnail_nibble_deinterleave.sv @@
// ---------------------------------------------------------------------------
// Thumbnail nibble deinterleaver testbench
// Streams raw thumbnail bytes into the block and predicts the two placed
// gray pixels of each byte in sequential and interleaved scan order. Output
// transfers are compared field by field with a queue of predicted pairs.
// The interleave mode is changed over APB between phases with different
// amounts of idling on both streams.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_thumbnail_nibble_deinterleave;
  timeunit 1ns;
  timeprecision 1ps;

  import tnd_pkg::*;

  // One predicted or observed output transfer.
  typedef struct {
    logic [XW-1:0]    first_x;
    logic [YW-1:0]    first_y;
    logic [GrayW-1:0] first_gray;
    logic [XW-1:0]    second_x;
    logic [YW-1:0]    second_y;
    logic [GrayW-1:0] second_gray;
    logic             frame_end;
  } pixel_pair_t;

  // Tracks the scan position of the block and checks each output pair.
  class pixel_pair_scoreboard;
    localparam int unsigned TripletLen = 3;

    logic        scan_mode;
    int unsigned nib_pos;
    int unsigned cur_row_pair;
    int unsigned errors;
    pixel_pair_t expected_pairs[$];

    function new();
      scan_mode    = ModeInterleaved;
      nib_pos      = 0;
      cur_row_pair = 0;
      errors       = 0;
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 40) $display("ERROR at %0t: %s", $time, msg);
    endtask

    function void set_mode(input logic m);
      scan_mode = m;
    endfunction

    function int unsigned pending();
      return expected_pairs.size();
    endfunction

    // Column and row of nibble p of the current two-line group.
    function void place_nibble(input int unsigned p, output logic [XW-1:0] x,
                               output logic [YW-1:0] y);
      int unsigned base_y;
      int unsigned px;
      int unsigned py;
      base_y = 2 * cur_row_pair;
      if (scan_mode == ModeSequential) begin
        if (p < ThumbWidth) begin
          px = p;
          py = base_y;
        end else begin
          px = p - ThumbWidth;
          py = base_y + 1;
        end
      end else if (p < TripletNibbles) begin
        // Triplets (x,y), (x+1,y), (x,y+1) for even x.
        px = 2 * (p / TripletLen) + (((p % TripletLen) == Ph1) ? 1 : 0);
        py = base_y + (((p % TripletLen) == Ph2) ? 1 : 0);
      end else begin
        // Remaining nibbles fill the odd columns of the lower line.
        px = 2 * (p - TripletNibbles) + 1;
        py = base_y + 1;
      end
      x = px[XW-1:0];
      y = py[YW-1:0];
    endfunction

    // Predict the pair for an accepted byte and advance the counters.
    function void note_byte(input logic [7:0] b);
      pixel_pair_t pr;
      logic        last;
      place_nibble(nib_pos, pr.first_x, pr.first_y);
      place_nibble(nib_pos + 1, pr.second_x, pr.second_y);
      last = (nib_pos + 2 >= GroupNibbles) && (cur_row_pair + 1 >= RowPairs);
      pr.first_gray  = {b[7:4], 4'h0};
      pr.second_gray = {b[3:0], 4'h0};
      pr.frame_end   = last;
      expected_pairs.push_back(pr);
      nib_pos += 2;
      if (nib_pos >= GroupNibbles) begin
        nib_pos      = 0;
        cur_row_pair = last ? 0 : cur_row_pair + 1;
      end
    endfunction

    task check_field(input string name, input int unsigned got,
                     input int unsigned want);
      if (got != want) report($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Compare an output transfer with the oldest prediction.
    task check_pair(input logic [47:0] tdata, input logic tlast);
      pixel_pair_t want;
      if (expected_pairs.size() == 0) begin
        report($sformatf("unexpected output transfer, tdata %h", tdata));
        return;
      end
      want = expected_pairs.pop_front();
      check_field("first_x", tdata[6:0], want.first_x);
      check_field("first_y", tdata[12:7], want.first_y);
      check_field("first_gray", tdata[20:13], want.first_gray);
      check_field("second_x", tdata[27:21], want.second_x);
      check_field("second_y", tdata[33:28], want.second_y);
      check_field("second_gray", tdata[41:34], want.second_gray);
      check_field("tdata fill", tdata[47:42], 0);
      check_field("frame_end", tlast, want.frame_end);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // first_x, first_y, first_gray, second_x,
                               // second_y, second_gray, zero fill
  logic        m_axis_tlast;   // frame_end

  pixel_pair_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  thumbnail_nibble_deinterleave dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // Receiver side stalls at random.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every output transfer is checked against the prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_pair(m_axis_tdata, m_axis_tlast);
    end
  end

  // Offer one byte, with random idle cycles before it, and wait for the
  // transfer. Called and returns at a falling edge.
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b);
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every predicted pair has been seen.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // APB write of the scan mode, then a read back of the register.
  task automatic write_mode(input logic m);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * RegInterleaveMode);
    pwdata  <= {31'b0, m};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    sb.set_mode(m);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {31'b0, sb.scan_mode}) begin
      sb.report($sformatf("mode register reads %h, expected %0d", prdata, sb.scan_mode));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One phase of random bytes under the given idling.
  task automatic random_phase(input int unsigned count, input int unsigned s_pct,
                              input int unsigned r_pct, input bit pause_midway);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) begin
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk_i);
      end
      push_byte(8'($urandom_range(255)));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed bytes in the reset mode, covering all triplet phases.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hF0);
    push_byte(8'h0F);
    push_byte(8'h5A);
    push_byte(8'hA5);
    push_byte(8'h01);
    push_byte(8'h80);
    drain();

    // Sequential mode from the middle of the group: the counters keep going.
    write_mode(ModeSequential);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h12);
    push_byte(8'h34);
    push_byte(8'hC3);
    push_byte(8'h3C);
    push_byte(8'h7E);
    push_byte(8'h81);
    drain();
    write_mode(ModeInterleaved);

    // Random phases with the mode switched between them.
    random_phase(512, 38, 83, 1'b0);
    drain();
    write_mode(ModeSequential);
    random_phase(512, 83, 38, 1'b1);
    drain();
    write_mode(ModeInterleaved);
    random_phase(512, 0, 0, 1'b0);

    drain();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+design
design/tnd_pkg.sv
design/tnd_pos_cnt.sv
design/tnd_lane.sv
design/thumbnail_nibble_deinterleave.sv
sim/tb_thumbnail_nibble_deinterleave.sv
